// ----- src/c65alu_pkg.sv -----
// ----------------------------------------------------------------------------
// c65alu_pkg
// Operation codes and status flag positions shared by the 6502-style
// execute unit.
// ----------------------------------------------------------------------------
package c65alu_pkg;

    // Operation code of one input word.
    typedef logic [5:0] t_kind;

    localparam t_kind K_ADC = 6'd0;
    localparam t_kind K_SBC = 6'd1;
    localparam t_kind K_AND = 6'd2;
    localparam t_kind K_ORA = 6'd3;
    localparam t_kind K_EOR = 6'd4;
    localparam t_kind K_CMP = 6'd5;
    localparam t_kind K_CPX = 6'd6;
    localparam t_kind K_CPY = 6'd7;
    localparam t_kind K_BIT = 6'd8;
    localparam t_kind K_LDA = 6'd9;
    localparam t_kind K_LDX = 6'd10;
    localparam t_kind K_LDY = 6'd11;
    localparam t_kind K_ASL = 6'd12;
    localparam t_kind K_LSR = 6'd13;
    localparam t_kind K_ROL = 6'd14;
    localparam t_kind K_ROR = 6'd15;
    localparam t_kind K_INC = 6'd16;
    localparam t_kind K_DEC = 6'd17;
    localparam t_kind K_INX = 6'd18;
    localparam t_kind K_DEX = 6'd19;
    localparam t_kind K_INY = 6'd20;
    localparam t_kind K_DEY = 6'd21;
    localparam t_kind K_TAX = 6'd22;
    localparam t_kind K_TAY = 6'd23;
    localparam t_kind K_TSX = 6'd24;
    localparam t_kind K_TXA = 6'd25;
    localparam t_kind K_TXS = 6'd26;
    localparam t_kind K_TYA = 6'd27;
    localparam t_kind K_CLC = 6'd28;
    localparam t_kind K_CLD = 6'd29;
    localparam t_kind K_CLI = 6'd30;
    localparam t_kind K_CLV = 6'd31;
    localparam t_kind K_SEC = 6'd32;
    localparam t_kind K_SED = 6'd33;
    localparam t_kind K_SEI = 6'd34;
    localparam t_kind K_STA = 6'd35;
    localparam t_kind K_STX = 6'd36;
    localparam t_kind K_STY = 6'd37;
    localparam t_kind K_BCC = 6'd38;
    localparam t_kind K_BCS = 6'd39;
    localparam t_kind K_BEQ = 6'd40;
    localparam t_kind K_BMI = 6'd41;
    localparam t_kind K_BNE = 6'd42;
    localparam t_kind K_BPL = 6'd43;
    localparam t_kind K_BVC = 6'd44;
    localparam t_kind K_BVS = 6'd45;

    // Bit positions in the status register.
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    // Register values after reset.
    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h34;

endpackage

// ----- src/cpu6502_alu_register_unit.sv -----
// ----------------------------------------------------------------------------
// cpu6502_alu_register_unit
// Execute unit of a 6502-style processor (binary arithmetic only) holding
// A, X, Y, SP and the status flags.
// ----------------------------------------------------------------------------
// Each accepted word is captured in an input register, executed against the
// register file, and the outcome lands in an output register while A, X, Y,
// SP and P are updated on the same edge. One word is taken per cycle while
// the output register is free or its result is being taken; output valid
// rises once the word has moved from the input register into the output register. The
// next word can be executed while a finished result still waits in the
// output register only once that result is taken, so a stall on the output
// holds at most one word in each of the two registers. Words with an unused
// operation code leave A, X, Y, SP and P unchanged and report no write and no
// branch.
module cpu6502_alu_register_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  c65alu_pkg::t_kind    i_kind,
    input  logic [7:0]           i_operand,
    input  logic                 i_to_accumulator,
    // Output channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_result,
    output logic                 o_mem_write,
    output logic                 o_branch_taken,
    output logic [7:0]           o_status_out,
    output logic [7:0]           o_acc_out,
    output logic [7:0]           o_x_out,
    output logic [7:0]           o_y_out,
    output logic [7:0]           o_sp_out
);
    import c65alu_pkg::*;

    // Input register.
    logic        r_in_valid;
    t_kind       r_kind;
    logic [7:0]  r_operand;
    logic        r_to_acc;

    // Register file.
    logic [7:0]  r_acc, n_acc;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [7:0]  r_sp, n_sp;
    logic [7:0]  r_status, n_status;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_result, n_result;
    logic        r_mem_write, n_mem_write;
    logic        r_branch, n_branch;

    logic        exec_fire;

    // Datapath intermediates.
    logic [7:0]  add_opnd;
    logic [8:0]  add_sum;
    logic [7:0]  cmp_reg;
    logic [8:0]  cmp_diff;
    logic [7:0]  sh_src;
    logic [7:0]  sh_val;
    logic        sh_cout;
    logic [7:0]  zn_val;
    logic        zn_en;

    // Handshake: the executing word moves on when the output register is free.
    assign exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec_fire;

    // Adder shared by ADC and SBC; SBC adds the inverted operand.
    assign add_opnd = (r_kind == K_SBC) ? ~r_operand : r_operand;
    assign add_sum  = {1'b0, r_acc} + {1'b0, add_opnd} + {8'd0, r_status[FL_C]};

    // Compare subtractor; bit 8 is the borrow.
    always_comb begin
        unique case (r_kind)
            K_CPX:   cmp_reg = r_x;
            K_CPY:   cmp_reg = r_y;
            default: cmp_reg = r_acc;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, r_operand};

    // Shifter for ASL, LSR, ROL and ROR.
    assign sh_src = r_to_acc ? r_acc : r_operand;
    always_comb begin
        unique case (r_kind)
            K_ASL: begin
                sh_val  = {sh_src[6:0], 1'b0};
                sh_cout = sh_src[7];
            end
            K_ROL: begin
                sh_val  = {sh_src[6:0], r_status[FL_C]};
                sh_cout = sh_src[7];
            end
            K_ROR: begin
                sh_val  = {r_status[FL_C], sh_src[7:1]};
                sh_cout = sh_src[0];
            end
            default: begin
                sh_val  = {1'b0, sh_src[7:1]};
                sh_cout = sh_src[0];
            end
        endcase
    end

    // Operation decode: next register file, write word and branch decision.
    always_comb begin
        n_acc       = r_acc;
        n_x         = r_x;
        n_y         = r_y;
        n_sp        = r_sp;
        n_status    = r_status;
        n_result    = 8'd0;
        n_mem_write = 1'b0;
        n_branch    = 1'b0;
        zn_val      = 8'd0;
        zn_en       = 1'b0;

        unique case (r_kind)
            K_ADC, K_SBC: begin
                n_acc          = add_sum[7:0];
                n_status[FL_C] = add_sum[8];
                n_status[FL_V] = ~(r_acc[7] ^ add_opnd[7]) & (r_acc[7] ^ add_sum[7]);
                zn_val         = add_sum[7:0];
                zn_en          = 1'b1;
            end
            K_AND: begin
                n_acc  = r_acc & r_operand;
                zn_val = r_acc & r_operand;
                zn_en  = 1'b1;
            end
            K_ORA: begin
                n_acc  = r_acc | r_operand;
                zn_val = r_acc | r_operand;
                zn_en  = 1'b1;
            end
            K_EOR: begin
                n_acc  = r_acc ^ r_operand;
                zn_val = r_acc ^ r_operand;
                zn_en  = 1'b1;
            end
            K_CMP, K_CPX, K_CPY: begin
                n_status[FL_C] = ~cmp_diff[8];
                zn_val         = cmp_diff[7:0];
                zn_en          = 1'b1;
            end
            K_BIT: begin
                n_status[FL_Z] = ((r_acc & r_operand) == 8'd0);
                n_status[FL_N] = r_operand[7];
                n_status[FL_V] = r_operand[6];
            end
            K_LDA: begin
                n_acc  = r_operand;
                zn_val = r_operand;
                zn_en  = 1'b1;
            end
            K_LDX: begin
                n_x    = r_operand;
                zn_val = r_operand;
                zn_en  = 1'b1;
            end
            K_LDY: begin
                n_y    = r_operand;
                zn_val = r_operand;
                zn_en  = 1'b1;
            end
            K_ASL, K_LSR, K_ROL, K_ROR: begin
                n_status[FL_C] = sh_cout;
                zn_val         = sh_val;
                zn_en          = 1'b1;
                if (r_to_acc) begin
                    n_acc = sh_val;
                end else begin
                    n_result    = sh_val;
                    n_mem_write = 1'b1;
                end
            end
            K_INC: begin
                n_result    = r_operand + 8'd1;
                n_mem_write = 1'b1;
                zn_val      = r_operand + 8'd1;
                zn_en       = 1'b1;
            end
            K_DEC: begin
                n_result    = r_operand - 8'd1;
                n_mem_write = 1'b1;
                zn_val      = r_operand - 8'd1;
                zn_en       = 1'b1;
            end
            K_INX: begin
                n_x    = r_x + 8'd1;
                zn_val = r_x + 8'd1;
                zn_en  = 1'b1;
            end
            K_DEX: begin
                n_x    = r_x - 8'd1;
                zn_val = r_x - 8'd1;
                zn_en  = 1'b1;
            end
            K_INY: begin
                n_y    = r_y + 8'd1;
                zn_val = r_y + 8'd1;
                zn_en  = 1'b1;
            end
            K_DEY: begin
                n_y    = r_y - 8'd1;
                zn_val = r_y - 8'd1;
                zn_en  = 1'b1;
            end
            K_TAX: begin
                n_x    = r_acc;
                zn_val = r_acc;
                zn_en  = 1'b1;
            end
            K_TAY: begin
                n_y    = r_acc;
                zn_val = r_acc;
                zn_en  = 1'b1;
            end
            K_TSX: begin
                n_x    = r_sp;
                zn_val = r_sp;
                zn_en  = 1'b1;
            end
            K_TXA: begin
                n_acc  = r_x;
                zn_val = r_x;
                zn_en  = 1'b1;
            end
            K_TXS: begin
                n_sp = r_x;
            end
            K_TYA: begin
                n_acc  = r_y;
                zn_val = r_y;
                zn_en  = 1'b1;
            end
            K_CLC: n_status[FL_C] = 1'b0;
            K_CLD: n_status[FL_D] = 1'b0;
            K_CLI: n_status[FL_I] = 1'b0;
            K_CLV: n_status[FL_V] = 1'b0;
            K_SEC: n_status[FL_C] = 1'b1;
            K_SED: n_status[FL_D] = 1'b1;
            K_SEI: n_status[FL_I] = 1'b1;
            K_STA: begin
                n_result    = r_acc;
                n_mem_write = 1'b1;
            end
            K_STX: begin
                n_result    = r_x;
                n_mem_write = 1'b1;
            end
            K_STY: begin
                n_result    = r_y;
                n_mem_write = 1'b1;
            end
            K_BCC: n_branch = ~r_status[FL_C];
            K_BCS: n_branch = r_status[FL_C];
            K_BEQ: n_branch = r_status[FL_Z];
            K_BMI: n_branch = r_status[FL_N];
            K_BNE: n_branch = ~r_status[FL_Z];
            K_BPL: n_branch = ~r_status[FL_N];
            K_BVC: n_branch = ~r_status[FL_V];
            K_BVS: n_branch = r_status[FL_V];
            default: begin
                // Unused codes leave the register file unchanged.
            end
        endcase

        // Zero and negative flags from the value the operation produced.
        if (zn_en) begin
            n_status[FL_Z] = (zn_val == 8'd0);
            n_status[FL_N] = zn_val[7];
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind    <= i_kind;
            r_operand <= i_operand;
            r_to_acc  <= i_to_accumulator;
        end
    end

    // Register file, updated when a word executes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 8'd0;
            r_x      <= 8'd0;
            r_y      <= 8'd0;
            r_sp     <= SP_RESET;
            r_status <= STATUS_RESET;
        end else if (exec_fire) begin
            r_acc    <= n_acc;
            r_x      <= n_x;
            r_y      <= n_y;
            r_sp     <= n_sp;
            r_status <= n_status;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_result    <= n_result;
            r_mem_write <= n_mem_write;
            r_branch    <= n_branch;
        end
    end

    // The register snapshot shown with a result is the file after that word.
    assign o_out_valid    = r_out_valid;
    assign o_result       = r_result;
    assign o_mem_write    = r_mem_write;
    assign o_branch_taken = r_branch;
    assign o_status_out   = r_status;
    assign o_acc_out      = r_acc;
    assign o_x_out        = r_x;
    assign o_y_out        = r_y;
    assign o_sp_out       = r_sp;

endmodule
